// ===== hw/rtl/fnvbkt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FNV-1a bucket index package
// Shared widths, hash constants, the queue status type and the hash step.
// ----------------------------------------------------------------------------
package fnvbkt_pkg;

    localparam int HASH_W  = 64;
    localparam int IDX_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int STEP_W  = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] FNV_OFFSET_BASIS = 64'hCBF29CE484222325;

    // The 64-bit prime is 2^40 + 0x1B3, so the product is a shift plus a
    // narrow multiply.
    localparam int               FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]       FNV_PRIME_LOW   = 9'h1B3;

    localparam logic [IDX_W-1:0] BUCKET_COUNT_RESET = 32'd25;
    localparam int               QUEUE_DEPTH        = 4;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] h);
        logic [HASH_W-1:0] low_part;
        low_part = h * HASH_W'(FNV_PRIME_LOW);
        return (h << FNV_PRIME_SHIFT) + low_part;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fnvbkt_key_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key byte channel
// Valid/ready channel carrying at most one key byte per beat.
// ----------------------------------------------------------------------------
interface fnvbkt_key_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, key_byte, has_byte, last, input ready);
    modport sink   (input valid, key_byte, has_byte, last, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fnvbkt_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the final hash and bucket index per beat.
// ----------------------------------------------------------------------------
interface fnvbkt_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic [31:0] bucket_index;

    modport source (output valid, hash_value, bucket_index, input ready);
    modport sink   (input valid, hash_value, bucket_index, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fnvbkt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FNV-1a front end
// Absorbs one key byte per cycle while the queue has room and pushes the finished hash into the queue.
// ----------------------------------------------------------------------------
module fnvbkt_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    fnvbkt_key_if.sink                          key_chan,
    input  wire fnvbkt_pkg::q_stat_t            q_stat,
    output logic                                push,
    output logic [fnvbkt_pkg::HASH_W-1:0]       push_hash
);

    logic [fnvbkt_pkg::HASH_W-1:0] hash_reg;
    logic [fnvbkt_pkg::HASH_W-1:0] hash_next;
    logic [fnvbkt_pkg::HASH_W-1:0] absorbed;
    logic [fnvbkt_pkg::HASH_W-1:0] hash_cur;
    logic                          accept;

    assign key_chan.ready = !q_stat.full;
    assign accept         = key_chan.valid && key_chan.ready;

    always_comb
    begin
        absorbed = fnvbkt_pkg::fnv_mul(hash_reg ^
                   {{(fnvbkt_pkg::HASH_W-fnvbkt_pkg::BYTE_W){1'b0}}, key_chan.key_byte});
        hash_cur = key_chan.has_byte ? absorbed : hash_reg;
        hash_next = hash_reg;
        if (accept)
        begin
            // The end of a key restarts the running hash for the next one.
            hash_next = key_chan.last ? fnvbkt_pkg::FNV_OFFSET_BASIS : hash_cur;
        end
    end

    assign push      = accept && key_chan.last;
    assign push_hash = hash_cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= fnvbkt_pkg::FNV_OFFSET_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/fnvbkt_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Hash queue
// Small first-in first-out buffer of finished hashes between front and back.
// ----------------------------------------------------------------------------
module fnvbkt_queue #(
    parameter int Depth = fnvbkt_pkg::QUEUE_DEPTH
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic [fnvbkt_pkg::HASH_W-1:0]  push_hash,
    input  wire logic                           pop,
    output logic [fnvbkt_pkg::HASH_W-1:0]       pop_hash,
    output fnvbkt_pkg::q_stat_t                 q_stat
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [fnvbkt_pkg::HASH_W-1:0] mem_reg [Depth];
    logic [PtrW-1:0]               wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]               rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]               count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    assign q_stat.full  = (count_reg == CntW'(Depth));
    assign q_stat.empty = (count_reg == '0);
    assign pop_hash     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_hash;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !push)
        else $error("hash pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.empty |-> !pop)
        else $error("hash popped from an empty queue");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/fnvbkt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bucket remainder unit
// Restoring remainder of the hash by the bucket count, one bit per cycle.
// ----------------------------------------------------------------------------
module fnvbkt_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire fnvbkt_pkg::q_stat_t            q_stat,
    input  wire logic [fnvbkt_pkg::HASH_W-1:0]  pop_hash,
    output logic                                pop,
    input  wire logic [fnvbkt_pkg::IDX_W-1:0]   bucket_count,
    fnvbkt_res_if.source                        res_chan
);

    localparam int HashW = fnvbkt_pkg::HASH_W;
    localparam int IdxW  = fnvbkt_pkg::IDX_W;
    localparam int StepW = fnvbkt_pkg::STEP_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [StepW-1:0] cnt_reg, cnt_next;
    logic [HashW-1:0] shift_reg, shift_next;
    logic [HashW-1:0] hash_reg, hash_next;
    logic [IdxW-1:0]  rem_reg, rem_next;
    logic [IdxW-1:0]  div_reg, div_next;
    logic             out_valid_reg, out_valid_next;
    logic [HashW-1:0] out_hash_reg, out_hash_next;
    logic [IdxW-1:0]  out_idx_reg, out_idx_next;

    logic [IdxW:0]    rem_shift;
    logic [IdxW:0]    rem_sub;
    logic [IdxW-1:0]  rem_step;
    logic [IdxW-1:0]  load_rem;
    logic             load;
    logic             out_free;

    always_comb
    begin
        // The remainder stays below the divisor, so one subtraction per step
        // is enough.
        rem_shift = {rem_reg, shift_reg[HashW-1]};
        rem_sub   = rem_shift - {1'b0, div_reg};
        rem_step  = (rem_shift >= {1'b0, div_reg}) ? rem_sub[IdxW-1:0] : rem_shift[IdxW-1:0];
        out_free  = !out_valid_reg || res_chan.ready;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        hash_next  = hash_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        pop        = 1'b0;
        load       = 1'b0;
        load_rem   = rem_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    shift_next = pop_hash;
                    hash_next  = pop_hash;
                    rem_next   = '0;
                    cnt_next   = '0;
                    div_next   = bucket_count;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                shift_next = shift_reg << 1;
                rem_next   = rem_step;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == StepW'(HashW - 1))
                begin
                    if (out_free)
                    begin
                        load       = 1'b1;
                        load_rem   = rem_step;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        out_idx_next   = out_idx_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_hash_next  = hash_reg;
            // A bucket count of zero gives bucket zero.
            out_idx_next   = (div_reg == '0) ? '0 : load_rem;
        end
        else if (res_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res_chan.valid        = out_valid_reg;
    assign res_chan.hash_value   = out_hash_reg;
    assign res_chan.bucket_index = out_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        hash_reg     <= hash_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
        out_hash_reg <= out_hash_next;
        out_idx_reg  <= out_idx_next;
    end

`ifndef SYNTHESIS
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (state_reg == ST_IDLE))
        else $error("queue popped while a division is in progress");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (load && div_reg != '0) |-> (load_rem < div_reg))
        else $error("bucket index not below bucket count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_chan.ready) |-> !load)
        else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/fnv1a_bucket_index.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// FNV-1a bucket index
// 64-bit FNV-1a hash of a byte-stream key, with the bucket index taken as the
// hash modulo a configurable bucket count.
// ----------------------------------------------------------------------------
//  Channel       Role    Beat carries
//  key_chan      sink    key_byte, has_byte, last
//  result_chan   source  hash_value, bucket_index
//  cfg_wr_*      write   bucket_count (32 bits, reset 25)
//
//  The hash front end takes one key beat per cycle while the hash queue has
//  room. For each key end the back end takes a hash from the queue and then
//  forms the remainder one hash bit a cycle. The queue holds up to
//  QueueDepth finished hashes, so short keys back up the key channel only
//  when it fills. The result register lets the next remainder run while a
//  result waits; reset restarts the running hash at the offset basis and
//  empties the queue.
// ----------------------------------------------------------------------------
module fnv1a_bucket_index #(
    parameter int QueueDepth = fnvbkt_pkg::QUEUE_DEPTH
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    fnvbkt_key_if.sink                         key_chan,
    fnvbkt_res_if.source                       result_chan,
    input  wire logic                          cfg_wr_en,
    input  wire logic [fnvbkt_pkg::IDX_W-1:0]  cfg_wr_data
);

    logic [fnvbkt_pkg::IDX_W-1:0]  bucket_count_reg;
    logic [fnvbkt_pkg::IDX_W-1:0]  bucket_count_next;
    logic                          push;
    logic [fnvbkt_pkg::HASH_W-1:0] push_hash;
    logic                          pop;
    logic [fnvbkt_pkg::HASH_W-1:0] pop_hash;
    fnvbkt_pkg::q_stat_t           q_stat;

    assign bucket_count_next = cfg_wr_en ? cfg_wr_data : bucket_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= fnvbkt_pkg::BUCKET_COUNT_RESET;
        end
        else
        begin
            bucket_count_reg <= bucket_count_next;
        end
    end

    fnvbkt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .key_chan  (key_chan),
        .q_stat    (q_stat),
        .push      (push),
        .push_hash (push_hash)
    );

    fnvbkt_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_hash (push_hash),
        .pop       (pop),
        .pop_hash  (pop_hash),
        .q_stat    (q_stat)
    );

    fnvbkt_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .pop_hash     (pop_hash),
        .pop          (pop),
        .bucket_count (bucket_count_reg),
        .res_chan     (result_chan)
    );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FNV-1a bucket index testbench
// Streams keys of random bytes into the block, byteless beats and empty keys
// among them, under a series of bucket counts. A scoreboard keeps its own
// running hash and checks every hash and bucket index that comes back.
// ----------------------------------------------------------------------------
module testbench;

    localparam int HASH_W = fnvbkt_pkg::HASH_W;
    localparam int IDX_W  = fnvbkt_pkg::IDX_W;

    localparam logic [HASH_W-1:0] KEY_OFFSET_BASIS = 64'd14695981039346656037;
    localparam logic [HASH_W-1:0] KEY_PRIME        = 64'd1099511628211;
    localparam int CYCLE_LIMIT  = 400000;
    // Idle clocks waited after the last expected result has come back.
    localparam int DRAIN_TAIL   = 300;
    localparam int PHASE_BEATS  = 125;
    localparam int NUM_PHASES   = 6;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [HASH_W-1:0] hash_value;
        logic [IDX_W-1:0]  bucket_index;
    } key_result_t;

    class fnv_key_tracker;
        logic [HASH_W-1:0] running_hash;
        logic [IDX_W-1:0]  bucket_count;
        key_result_t       expected_results[$];
        int                mismatches;
        int                results_seen;
        int                keys_ended;
        int                beats_taken;

        function new();
            running_hash = KEY_OFFSET_BASIS;
            bucket_count = fnvbkt_pkg::BUCKET_COUNT_RESET;
            mismatches   = 0;
            results_seen = 0;
            keys_ended   = 0;
            beats_taken  = 0;
        endfunction

        function void set_bucket_count(input logic [IDX_W-1:0] count);
            bucket_count = count;
        endfunction

        function void take_key_beat(input logic [7:0] key_byte, input logic has_byte,
                                    input logic last);
            key_result_t res;
            if (has_byte || last)
                beats_taken++;
            if (has_byte)
                running_hash = (running_hash ^ {{(HASH_W-8){1'b0}}, key_byte}) * KEY_PRIME;
            if (last)
            begin
                res.hash_value = running_hash;
                if (bucket_count == '0)
                    res.bucket_index = '0;
                else
                    res.bucket_index = IDX_W'(running_hash % {{(HASH_W-IDX_W){1'b0}},
                                                              bucket_count});
                expected_results.push_back(res);
                running_hash = KEY_OFFSET_BASIS;
                keys_ended++;
            end
        endfunction

        function void check_result(input logic [HASH_W-1:0] hash_value,
                                   input logic [IDX_W-1:0] bucket_index);
            key_result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result beat: hash %h bucket %0d",
                             hash_value, bucket_index);
                return;
            end
            want = expected_results.pop_front();
            if (hash_value !== want.hash_value || bucket_index !== want.bucket_index)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: expected hash %h bucket %0d, got hash %h bucket %0d",
                             results_seen, want.hash_value, want.bucket_index,
                             hash_value, bucket_index);
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_wr_data;
    bit               calm_stretch;
    int               cycle_count = 0;
    int               settings_used = 1;
    logic [IDX_W-1:0] phase_counts [NUM_PHASES];

    fnv_key_tracker tracker = new();

    fnvbkt_key_if key_if ();
    fnvbkt_res_if res_if ();

    fnv1a_bucket_index u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .key_chan    (key_if),
        .result_chan (res_if),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, tracker.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (calm_stretch)
            res_if.ready <= 1'b1;
        else
            res_if.ready <= ($urandom_range(0, 99) >= 34);
    end

    // Both sides only change at the rising edge, so a handshake seen at the
    // falling edge is the one taken at the next rising edge.
    always @(negedge clk)
    begin
        if (rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1)
            tracker.check_result(res_if.hash_value, res_if.bucket_index);
    end

    task automatic send_beat(input logic [7:0] key_byte, input logic has_byte,
                             input logic last);
        while (!calm_stretch && $urandom_range(0, 99) < 34)
        begin
            key_if.valid    <= 1'b0;
            key_if.key_byte <= 8'($urandom);
            @(posedge clk);
        end
        key_if.valid    <= 1'b1;
        key_if.key_byte <= key_byte;
        key_if.has_byte <= has_byte;
        key_if.last     <= last;
        do
            @(negedge clk);
        while (key_if.ready !== 1'b1);
        @(posedge clk);
        tracker.take_key_beat(key_byte, has_byte, last);
    endtask

    // A key of nbytes random bytes, closed either by its final byte or by a
    // byteless beat; now and then a byteless beat that changes nothing.
    task automatic send_key(input int nbytes, input bit empty_tail);
        int i;
        for (i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_beat(8'($urandom), 1'b0, 1'b0);
            send_beat(8'($urandom), 1'b1, (!empty_tail && i == nbytes - 1));
        end
        if (empty_tail || nbytes == 0)
            send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic random_keys(input int beat_budget);
        int start_beats;
        int nbytes;
        int i;
        start_beats = tracker.beats_taken;
        while (tracker.beats_taken - start_beats < beat_budget)
        begin
            case ($urandom_range(0, 9))
                0:       nbytes = 0;
                1:       nbytes = $urandom_range(20, 48);
                default: nbytes = $urandom_range(1, 8);
            endcase
            if ($urandom_range(0, 19) == 0)
            begin
                for (i = 0; i < $urandom_range(1, 4); i++)
                    send_beat(8'($urandom), 1'b0, 1'b0);
            end
            send_key(nbytes, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic drain_results();
        key_if.valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic write_bucket_count(input logic [IDX_W-1:0] count);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_bucket_count(count);
        settings_used++;
        @(posedge clk);
    endtask

    initial
    begin
        int p;
        key_if.valid    = 1'b0;
        key_if.key_byte = 8'h00;
        key_if.has_byte = 1'b0;
        key_if.last     = 1'b0;
        res_if.ready    = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        calm_stretch    = 1'b0;
        rst_n           = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed keys under the reset bucket count.
        send_beat(8'h00, 1'b0, 1'b1);       // empty key gives the offset basis
        send_beat(8'h00, 1'b1, 1'b1);       // zero byte hashed, together with last
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h5A, 1'b0, 1'b0);       // byteless beat before the key
        send_beat(8'h61, 1'b1, 1'b0);
        send_beat(8'hC3, 1'b0, 1'b1);       // key closed by a byteless beat
        send_beat(8'h41, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b0);       // zero byte does not end the key
        send_beat(8'h42, 1'b1, 1'b1);
        send_beat(8'h80, 1'b1, 1'b0);
        send_beat(8'h7F, 1'b1, 1'b0);
        send_beat(8'h55, 1'b1, 1'b0);
        send_beat(8'hAA, 1'b1, 1'b0);
        send_beat(8'h01, 1'b1, 1'b1);
        drain_results();

        write_bucket_count('0);             // zero bucket count gives index 0
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hFF, 1'b1, 1'b1);
        drain_results();
        write_bucket_count(32'd1);
        send_beat(8'h33, 1'b1, 1'b1);
        drain_results();
        write_bucket_count(32'hFFFF_FFFF);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'hEE, 1'b1, 1'b1);
        drain_results();

        phase_counts[0] = 32'hFFFF_FFFF;
        phase_counts[1] = 32'($urandom_range(2, 100));
        phase_counts[2] = 32'($urandom);
        phase_counts[3] = '0;
        phase_counts[4] = 32'h8000_0000;
        phase_counts[5] = 32'd1;
        for (p = 0; p < NUM_PHASES; p++)
        begin
            write_bucket_count(phase_counts[p]);
            calm_stretch = (p == 2);
            random_keys(PHASE_BEATS);
            calm_stretch = 1'b0;
            drain_results();
        end

        $display("covered %0d keys in %0d key beats over %0d bucket-count settings",
                 tracker.keys_ended, tracker.beats_taken, settings_used);
        $display("%0d results compared, %0d mismatched", tracker.results_seen,
                 tracker.mismatches);
        if (tracker.pending() != 0)
            $display("%0d expected results never arrived", tracker.pending());
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/fnvbkt_pkg.sv
hw/rtl/fnvbkt_key_if.sv
hw/rtl/fnvbkt_res_if.sv
hw/rtl/fnvbkt_front.sv
hw/rtl/fnvbkt_queue.sv
hw/rtl/fnvbkt_div.sv
hw/rtl/fnv1a_bucket_index.sv
sim/testbench.sv
